@@ rtl/mclp_pkg.sv @@
// Shared types and constants for the multi-channel load cell converter poller.
package mclp_pkg;

  // Fixed widths of the pins and reported readings.
  localparam int LINE_W    = 4;
  localparam int CHAN_W    = 2;
  localparam int READING_W = 24;
  localparam int HALF_W    = 16;

  // Reset value of the half period register.
  localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd16;

  // Sequencer phase of the serial clock.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  // One tick of input.
  typedef struct packed {
    logic [LINE_W-1:0] data_lines;
    logic [CHAN_W-1:0] query_channel;
  } item_t;

  // One tick of result.
  typedef struct packed {
    logic [LINE_W-1:0]           clock_lines;
    logic                        sample_done;
    logic [CHAN_W-1:0]           sample_channel;
    logic signed [READING_W-1:0] sample_value;
    logic signed [READING_W-1:0] query_value;
  } result_t;

endpackage

@@ rtl/mclp_core.sv @@
// Pin sequencer, per-channel reading store and half period register.
module mclp_core #(
  parameter int NUM_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  mclp_pkg::item_t               item,
  input  logic                          cfg_write,
  input  logic [mclp_pkg::HALF_W-1:0]   cfg_data,
  output mclp_pkg::result_t             result
);
  import mclp_pkg::*;

  localparam int PW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW  = $clog2(SAMPLE_BITS + 2);
  localparam logic [CW-1:0] LAST_BIT  = CW'(SAMPLE_BITS);
  localparam logic [CW-1:0] LAST_PULSE = CW'(SAMPLE_BITS + 1);
  localparam logic [PW-1:0] LAST_CHAN = PW'(NUM_CHANNELS - 1);

  logic [HALF_W-1:0]           half_period;
  logic [PW-1:0]               channel_pointer, channel_pointer_next;
  phase_t                      phase, phase_next;
  logic [CW-1:0]               pulse_count, pulse_count_next;
  logic [HALF_W-1:0]           phase_timer, phase_timer_next;
  logic [SAMPLE_BITS-1:0]      shift_word, shift_word_next;
  logic [READING_W-1:0]        stored_readings [NUM_CHANNELS];

  logic [HALF_W-1:0]           hp;
  logic                        half_end;
  logic                        has_line;
  logic                        line_level;
  logic [CHAN_W-1:0]           chan_lo;
  logic [PW-1:0]               next_chan;
  logic                        store;
  logic signed [SAMPLE_BITS-1:0] word_signed;
  logic [READING_W-1:0]        reading;
  logic [PW-1:0]               query_idx;

  // Half period register; zero behaves as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_write) begin
      half_period <= cfg_data;
    end
  end

  assign hp       = (half_period == '0) ? HALF_W'(1) : half_period;
  assign half_end = ({1'b0, phase_timer} + 17'd1) >= {1'b0, hp};

  // Data line of the active channel; channels without a pin read not ready.
  assign chan_lo    = CHAN_W'(channel_pointer);
  assign has_line   = 32'(channel_pointer) < LINE_W;
  assign line_level = has_line ? item.data_lines[chan_lo] : 1'b1;
  assign next_chan  = (channel_pointer == LAST_CHAN) ? '0 : channel_pointer + PW'(1);

  assign word_signed = shift_word;
  assign reading     = READING_W'(word_signed);

  // Next state of the sequencer.
  always_comb begin
    channel_pointer_next = channel_pointer;
    phase_next           = phase;
    pulse_count_next     = pulse_count;
    phase_timer_next     = phase_timer;
    shift_word_next      = shift_word;
    store                = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (!line_level) begin
          phase_next       = PH_HIGH;
          phase_timer_next = '0;
          pulse_count_next = '0;
          shift_word_next  = '0;
        end else begin
          channel_pointer_next = next_chan;
        end
      end
      PH_HIGH: begin
        if (half_end) begin
          if (pulse_count < LAST_BIT) begin
            shift_word_next = {shift_word[SAMPLE_BITS-2:0], line_level};
          end
          phase_next       = PH_LOW;
          phase_timer_next = '0;
        end else begin
          phase_timer_next = phase_timer + HALF_W'(1);
        end
      end
      PH_LOW: begin
        if (half_end) begin
          phase_timer_next = '0;
          if (pulse_count + CW'(1) >= LAST_PULSE) begin
            store                = 1'b1;
            pulse_count_next     = '0;
            shift_word_next      = '0;
            phase_next           = PH_IDLE;
            channel_pointer_next = next_chan;
          end else begin
            pulse_count_next = pulse_count + CW'(1);
            phase_next       = PH_HIGH;
          end
        end else begin
          phase_timer_next = phase_timer + HALF_W'(1);
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Sequencer registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_pointer <= '0;
      phase           <= PH_IDLE;
      pulse_count     <= '0;
      phase_timer     <= '0;
      shift_word      <= '0;
    end else if (accept) begin
      channel_pointer <= channel_pointer_next;
      phase           <= phase_next;
      pulse_count     <= pulse_count_next;
      phase_timer     <= phase_timer_next;
      shift_word      <= shift_word_next;
    end
  end

  // Reading store, one register per channel, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        stored_readings[i] <= '0;
      end
    end else if (accept && store) begin
      stored_readings[channel_pointer] <= reading;
    end
  end

  assign query_idx = PW'(item.query_channel);

  // Result fields, from the state held at the start of the tick.
  always_comb begin
    result.clock_lines = '0;
    if (phase == PH_HIGH && has_line) begin
      result.clock_lines[chan_lo] = 1'b1;
    end
    result.sample_done    = store;
    result.sample_channel = store ? chan_lo : '0;
    result.sample_value   = store ? reading : '0;
    result.query_value    = (32'(item.query_channel) < NUM_CHANNELS) ?
                            stored_readings[query_idx] : '0;
  end

endmodule

@@ rtl/mclp_out_buf.sv @@
// Two-entry result buffer that parts the item side from the result side.
module mclp_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mclp_pkg::result_t  push_data,
  output logic               full,
  output logic               result_valid,
  input  logic               result_stall,
  output mclp_pkg::result_t  result
);
  import mclp_pkg::*;

  logic    skid_valid;
  result_t skid;
  logic    pop;

  assign pop  = result_valid && !result_stall;
  assign full = skid_valid;

  // Control: the skid entry fills only when the output entry is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  // Payload of both entries.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        result <= skid;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid <= push_data;
      end else begin
        result <= push_data;
      end
    end
  end

endmodule

@@ rtl/multi_channel_load_cell_adc_poller.sv @@
// Top level of the round-robin load cell converter poller.
//
//  channel  direction  handshake                payload
//  item     in         item_valid / item_stall  item_t: data_lines, query_channel
//  result   out        result_valid / result_stall  result_t: pins, reading, query
//  cfg      in         cfg_valid / cfg_ready    cfg_data: half_period_ticks
//
// One tick is taken per clock cycle while item_stall is low; its result is
// registered in the result buffer. The sequencer state and reading store update in
// the cycle of the transfer. A two-entry result buffer keeps items flowing
// while one result is held; item_stall rises only when both entries are full.
// Reset clears the sequencer and stored readings and sets the half period to 16.
module multi_channel_load_cell_adc_poller #(
  parameter int NUM_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  mclp_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output mclp_pkg::result_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mclp_pkg::HALF_W-1:0] cfg_data
);
  import mclp_pkg::*;

  logic    accept;
  logic    full;
  result_t tick_result;

  assign item_stall = full;
  assign accept     = item_valid && !full;
  assign cfg_ready  = 1'b1;

  // Sequencer and reading store.
  mclp_core #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .result   (tick_result)
  );

  // Result register with skid entry.
  mclp_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_data   (tick_result),
    .full        (full),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

@@ rtl/mclp_checker.sv @@
// Port-level checks for the poller, bound to the top level.
module mclp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input mclp_pkg::result_t result
);
  import mclp_pkg::*;

  // A held result stays put until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("held result changed");

  // Items stall only while a result is waiting.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item stall without a pending result");

  // At most one serial clock is driven high at a time.
  a_one_clock: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(result.clock_lines))
    else $error("more than one clock line high");

  // A reading completes during a low phase, so no clock is high then.
  a_done_low: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sample_done |-> result.clock_lines == '0)
    else $error("reading completed with a clock line high");

  // Without a completed reading the sample fields are zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.sample_done |->
      result.sample_value == '0 && result.sample_channel == '0)
    else $error("sample fields set without a completed reading");

endmodule

bind multi_channel_load_cell_adc_poller mclp_checker u_mclp_checker (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);
